[rtl/wsjd_pkg.sv]
// Shared types, codes and widths for the work-stealing job dispatcher.
`timescale 1ns / 1ps

package wsjd_pkg;

  localparam int DEF_NUM_WORKERS = 8;
  localparam int DEF_STACK_DEPTH = 16;
  localparam int DEF_TOKEN_WIDTH = 32;

  localparam int KIND_W   = 1;
  localparam int WORKER_W = 3;
  localparam int TOKEN_W  = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 4;
  localparam int SCAN_W   = 5;

  localparam logic [CFG_W-1:0] WORKERS_RESET = 4'd8;

  localparam logic [KIND_W-1:0] KIND_SUBMIT = 1'b0;
  localparam logic [KIND_W-1:0] KIND_FETCH  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_SUBMITTED  = 2'd0,
    STATUS_HANDED_OUT = 2'd1,
    STATUS_NO_JOB     = 2'd2,
    STATUS_DROPPED    = 2'd3
  } status_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic respond;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_valid;
  } dp_stat_t;

endpackage

[rtl/wsjd_ifs.sv]
// Valid/ready channel interfaces for request and response words.
`timescale 1ns / 1ps

interface wsjd_req_if;
  logic                          valid;
  logic                          ready;
  logic [wsjd_pkg::KIND_W-1:0]   kind;
  logic [wsjd_pkg::WORKER_W-1:0] worker;
  logic [wsjd_pkg::TOKEN_W-1:0]  job_token;

  modport source (output valid, kind, worker, job_token, input ready);
  modport sink (input valid, kind, worker, job_token, output ready);
endinterface

interface wsjd_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [wsjd_pkg::STATUS_W-1:0] status;
  logic [wsjd_pkg::TOKEN_W-1:0]  job_token_res;
  logic [wsjd_pkg::WORKER_W-1:0] source_worker;
  logic                          all_finished;

  modport source (output valid, status, job_token_res, source_worker, all_finished,
                  input ready);
  modport sink (input valid, status, job_token_res, source_worker, all_finished,
                output ready);
endinterface

[rtl/wsjd_ctrl.sv]
// Controller state machine sequencing accept, execute and respond steps.
`timescale 1ns / 1ps

module wsjd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic                rsp_ready,
  input  wsjd_pkg::dp_stat_t  stat,
  output wsjd_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;
  logic   accept;

  assign slot_free = !stat.out_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE) || ((state == ST_RESP) && slot_free);
  assign accept    = req_valid && req_ready;

  assign cmd.load_item = accept;
  assign cmd.exec      = (state == ST_EXEC);
  assign cmd.respond   = (state == ST_RESP) && slot_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (slot_free) begin
          state_next = accept ? ST_EXEC : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/wsjd_dp.sv]
// Datapath: job stack memory, fill counts, round-robin pointer, scan and result register.
`timescale 1ns / 1ps

module wsjd_dp #(
  parameter int NUM_WORKERS = wsjd_pkg::DEF_NUM_WORKERS,
  parameter int STACK_DEPTH = wsjd_pkg::DEF_STACK_DEPTH,
  parameter int TOKEN_WIDTH = wsjd_pkg::DEF_TOKEN_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wsjd_pkg::ctrl_cmd_t           cmd,
  output wsjd_pkg::dp_stat_t            stat,
  input  logic                          cfg_we,
  input  logic [wsjd_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [wsjd_pkg::KIND_W-1:0]   req_kind,
  input  logic [wsjd_pkg::WORKER_W-1:0] req_worker,
  input  logic [wsjd_pkg::TOKEN_W-1:0]  req_token,
  input  logic                          rsp_ready,
  output logic                          rsp_valid,
  output logic [wsjd_pkg::STATUS_W-1:0] rsp_status,
  output logic [wsjd_pkg::TOKEN_W-1:0]  rsp_token,
  output logic [wsjd_pkg::WORKER_W-1:0] rsp_source,
  output logic                          rsp_all_finished
);

  localparam int SW = wsjd_pkg::SCAN_W;
  localparam int WW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_WORKERS * STACK_DEPTH;
  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic [TOKEN_WIDTH-1:0] mem [MEM_DEPTH];
  logic [TOKEN_WIDTH-1:0] rd_data;

  logic [wsjd_pkg::CFG_W-1:0] workers_in_use;
  logic [FW-1:0]              fill [NUM_WORKERS];
  logic [WW-1:0]              ptr;
  logic [NUM_WORKERS-1:0]     marks;

  logic [wsjd_pkg::KIND_W-1:0] item_kind;
  logic [wsjd_pkg::WORKER_W-1:0] item_worker;
  logic [TOKEN_WIDTH-1:0]      item_token;

  wsjd_pkg::status_t res_status;
  logic [WW-1:0]     res_source;

  logic [SW-1:0]          act;
  logic [SW-1:0]          req5;
  logic                   req_ok;
  logic [WW-1:0]          req_idx;
  logic [NUM_WORKERS-1:0] nonempty;
  logic [NUM_WORKERS-1:0] active_mask;
  logic [SW-1:0]          cand_sum [NUM_WORKERS];
  logic [WW-1:0]          cand_idx [NUM_WORKERS];
  logic [NUM_WORKERS-1:0] cand_ok;
  logic                   scan_hit;
  logic [WW-1:0]          scan_idx;
  logic [WW-1:0]          sub_idx;
  logic [WW-1:0]          ptr_next;
  logic                   sub_full;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          raddr;
  logic                   do_write;
  logic                   do_pop;
  logic                   is_submit;

  // Out-of-range register values clamp to the legal worker count.
  always_comb begin
    if (workers_in_use == '0) begin
      act = SW'(1);
    end else if (SW'(workers_in_use) > SW'(NUM_WORKERS)) begin
      act = SW'(NUM_WORKERS);
    end else begin
      act = SW'(workers_in_use);
    end
  end

  assign is_submit = (item_kind == wsjd_pkg::KIND_SUBMIT);
  assign req5      = SW'(item_worker);
  assign req_ok    = (req5 < act);
  assign req_idx   = WW'(req5);

  always_comb begin
    for (int i = 0; i < NUM_WORKERS; i++) begin
      nonempty[i]    = (fill[i] != '0);
      active_mask[i] = (SW'(i) < act);
    end
  end

  // Rotating priority pick: candidate k is the stack k places after the requester.
  always_comb begin
    for (int k = 0; k < NUM_WORKERS; k++) begin
      cand_sum[k] = req5 + SW'(k);
      cand_idx[k] = (cand_sum[k] >= act) ? WW'(cand_sum[k] - act) : WW'(cand_sum[k]);
      cand_ok[k]  = (SW'(k) < act) && nonempty[cand_idx[k]];
    end
  end

  always_comb begin
    scan_hit = 1'b0;
    scan_idx = '0;
    for (int k = NUM_WORKERS - 1; k >= 0; k--) begin
      if (cand_ok[k]) begin
        scan_hit = 1'b1;
        scan_idx = cand_idx[k];
      end
    end
  end

  always_comb begin
    sub_idx  = (SW'(ptr) >= act) ? '0 : ptr;
    ptr_next = ((SW'(sub_idx) + SW'(1)) == act) ? '0 : WW'(SW'(sub_idx) + SW'(1));
    sub_full = (fill[sub_idx] >= FW'(STACK_DEPTH));
  end

  assign waddr    = AW'(sub_idx) * AW'(STACK_DEPTH) + AW'(fill[sub_idx]);
  assign raddr    = AW'(scan_idx) * AW'(STACK_DEPTH) + AW'(fill[scan_idx]) - AW'(1);
  assign do_write = cmd.exec && is_submit && !sub_full;
  assign do_pop   = cmd.exec && !is_submit && req_ok && scan_hit;

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[waddr] <= item_token;
    end
    if (do_pop) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_kind   <= req_kind;
      item_worker <= req_worker;
      item_token  <= TOKEN_WIDTH'(req_token);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      workers_in_use <= wsjd_pkg::WORKERS_RESET;
    end else if (cfg_we) begin
      workers_in_use <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= '0;
      marks <= '0;
      for (int i = 0; i < NUM_WORKERS; i++) begin
        fill[i] <= '0;
      end
    end else if (cmd.exec) begin
      if (is_submit) begin
        ptr <= ptr_next;
        if (!sub_full) begin
          fill[sub_idx] <= fill[sub_idx] + FW'(1);
        end
      end else if (req_ok) begin
        if (scan_hit) begin
          fill[scan_idx] <= fill[scan_idx] - FW'(1);
          marks[req_idx] <= 1'b0;
        end else begin
          marks[req_idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (is_submit) begin
        res_source <= sub_idx;
        res_status <= sub_full ? wsjd_pkg::STATUS_DROPPED : wsjd_pkg::STATUS_SUBMITTED;
      end else if (req_ok && scan_hit) begin
        res_source <= scan_idx;
        res_status <= wsjd_pkg::STATUS_HANDED_OUT;
      end else begin
        res_source <= '0;
        res_status <= wsjd_pkg::STATUS_NO_JOB;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.respond) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      rsp_status       <= res_status;
      rsp_token        <= (res_status == wsjd_pkg::STATUS_HANDED_OUT) ?
                          wsjd_pkg::TOKEN_W'(rd_data) : '0;
      rsp_source       <= wsjd_pkg::WORKER_W'(res_source);
      rsp_all_finished <= &(marks | ~active_mask);
    end
  end

  assign stat.out_valid = rsp_valid;

endmodule

[rtl/work_stealing_job_dispatcher_core.sv]
// Top level of the work-stealing job dispatcher: controller, datapath and checks.
//
// Requests arrive as words on req_ch (kind, worker, job_token) and results leave as
// words on rsp_ch (status, job_token_res, source_worker, all_finished), both with
// valid/ready handshakes. Every request yields exactly one result word, in order.
// cfg_we with cfg_wdata writes the active worker count; write it only while idle.
// A request is registered on acceptance, executed in the execute state, and its result
// is loaded into the output register in the respond state. No new request is taken while
// one executes: the stack memory's registered read follows the step that picks the stack.
// The next request is accepted in the same cycle a result enters the output register.
// A stalled receiver holds the result in the output register; one more request is
// taken and executed, then the block waits for the output register to drain.
// Synchronous reset empties every stack, clears the finished marks and the submit
// pointer, and sets the active worker count to eight. The stack memory itself is not
// cleared; no clearing pass is needed, so requests are taken right after reset.
`timescale 1ns / 1ps

module work_stealing_job_dispatcher_core #(
  parameter int NUM_WORKERS = wsjd_pkg::DEF_NUM_WORKERS,
  parameter int STACK_DEPTH = wsjd_pkg::DEF_STACK_DEPTH,
  parameter int TOKEN_WIDTH = wsjd_pkg::DEF_TOKEN_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  wsjd_req_if.sink                   req_ch,
  wsjd_rsp_if.source                 rsp_ch,
  input  logic                       cfg_we,
  input  logic [wsjd_pkg::CFG_W-1:0] cfg_wdata
);

  wsjd_pkg::ctrl_cmd_t cmd;
  wsjd_pkg::dp_stat_t  stat;

  wsjd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_ch.valid),
    .req_ready (req_ch.ready),
    .rsp_ready (rsp_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wsjd_dp #(
    .NUM_WORKERS (NUM_WORKERS),
    .STACK_DEPTH (STACK_DEPTH),
    .TOKEN_WIDTH (TOKEN_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .req_kind         (req_ch.kind),
    .req_worker       (req_ch.worker),
    .req_token        (req_ch.job_token),
    .rsp_ready        (rsp_ch.ready),
    .rsp_valid        (rsp_ch.valid),
    .rsp_status       (rsp_ch.status),
    .rsp_token        (rsp_ch.job_token_res),
    .rsp_source       (rsp_ch.source_worker),
    .rsp_all_finished (rsp_ch.all_finished)
  );

`ifndef SYNTHESIS
  // The cycle after a request is taken is spent executing it, so none is taken then.
  assert property (@(posedge clk) disable iff (rst)
    (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
    else $error("request accepted during execute cycle");

  // Only a handed-out job carries a nonzero token.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_ch.valid && (rsp_ch.status != wsjd_pkg::STATUS_HANDED_OUT))
      |-> (rsp_ch.job_token_res == '0))
    else $error("token present on a result that hands out no job");

  // A fetch that finds no job reports stack zero.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_ch.valid && (rsp_ch.status == wsjd_pkg::STATUS_NO_JOB))
      |-> (rsp_ch.source_worker == '0))
    else $error("nonzero source on a no-job result");
`endif

endmodule
